FILE: src/deadline_ordered_timer_queue_unit_defines.svh
// Assertion helpers for the timer queue.
`ifndef DEADLINE_ORDERED_TIMER_QUEUE_UNIT_DEFINES_SVH
`define DEADLINE_ORDERED_TIMER_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define DOTQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define DOTQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dotq_pkg.sv
`default_nettype none
package dotq_pkg;

    localparam int TimeW    = 64;
    localparam int HandleW  = 16;
    localparam int CfgW     = 32;
    localparam int CfgIdxW  = 2;

    // input word kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_ABS   = 2'd1;
    localparam logic [1:0] KIND_DELAY = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // result kinds
    localparam logic [2:0] RES_EXPIRED = 3'd0;
    localparam logic [2:0] RES_ADDED   = 3'd1;
    localparam logic [2:0] RES_FULL    = 3'd2;
    localparam logic [2:0] RES_TICK    = 3'd3;
    localparam logic [2:0] RES_TIME    = 3'd4;

    // config register indexes
    localparam logic [CfgIdxW-1:0] CFG_TICK  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_SCHED = 2'd1;

    localparam logic [CfgW-1:0] TICK_PERIOD_RST  = 32'd1000000;
    localparam logic [CfgW-1:0] SCHED_PERIOD_RST = 32'd10000000;

    typedef struct packed {
        logic [1:0]         kind;
        logic [HandleW-1:0] entry_handle;
        logic [TimeW-1:0]   when_ns;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         result_kind;
        logic [HandleW-1:0] fired_handle;
        logic [TimeW-1:0]   now_ns;
        logic               preempt_due;
        logic               last;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK_ADD,
        ST_POP_RD,
        ST_POP_CMP,
        ST_PRE_CMP,
        ST_PRE_ADD,
        ST_ADD_DL,
        ST_INS_RD,
        ST_INS_CMP
    } t_state;

endpackage
`default_nettype wire

FILE: src/dotq_ram.sv
`default_nettype none
module dotq_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 80
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: src/dotq_alu.sv
`default_nettype none
module dotq_alu
    import dotq_pkg::*;
(
    input  wire logic [TimeW-1:0] i_a,
    input  wire logic [TimeW-1:0] i_b,
    output logic      [TimeW-1:0] o_sum,
    output logic                  o_le
);

    // shared time unit: wrapping add and unsigned a <= b
    assign o_sum = i_a + i_b;
    assign o_le  = (i_a <= i_b);

endmodule
`default_nettype wire

FILE: src/deadline_ordered_timer_queue_unit.sv
`default_nettype none
`include "deadline_ordered_timer_queue_unit_defines.svh"
// Deadline-ordered timer queue.
// Command channel: drive i_in and raise start; the word is taken at the edge
// where start is high and busy is low. busy stays high while it is worked on.
// Result channel: each result word is on o_out for one cycle with o_strobe
// high; the receiver cannot stall, so words are never held back.
// Config: i_cfg_we/i_cfg_idx/i_cfg_data, index 0 tick period, 1 sched period;
// other indexes are ignored. Write only while idle.
// Operation (one shared 64-bit add/compare unit, one-port-read queue RAM):
//   read time, rejected add: result in the cycle after accept, no busy time.
//   add: compute the deadline, then read and compare entries back from the
//   tail until an earlier or equal entry or the head ends the walk.
//   tick: advance time, pop expired entries until an unexpired head or an
//   empty queue ends the walk, then advance the preempt deadline when due;
//   one expired word per popped entry, the tick-done word last.
// The queue is a ring in RAM; pops advance the head, inserts walk back from
// the tail moving each later entry up one slot.
// Reset (synchronous, active low) clears time, preempt deadline, count and
// the periods to their defaults; RAM contents need no clearing.
module deadline_ordered_timer_queue_unit
    import dotq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire t_in_word           i_in,
    output logic                    o_strobe,
    output t_out_word               o_out,
    input  wire logic               i_cfg_we,
    input  wire logic [CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [CfgW-1:0]    i_cfg_data
);

    localparam int SB  = (HANDLE_BITS < HandleW) ? HANDLE_BITS : HandleW;
    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int SW  = PW + 1;
    localparam int EW  = TimeW + SB;

    t_state           r_state, n_state;
    logic [TimeW-1:0] r_now, n_now;
    logic [TimeW-1:0] r_npt, n_npt;
    logic [CfgW-1:0]  r_tick, r_sched;
    logic [CW-1:0]    r_count, n_count;
    logic [PW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_pos, n_pos;
    logic [TimeW-1:0] r_dl, n_dl;
    logic [SB-1:0]    r_handle, n_handle;
    logic             r_delay, n_delay;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out, n_out;

    logic [TimeW-1:0] alu_a, alu_b, alu_sum;
    logic             alu_le;
    logic             ram_we;
    logic [PW-1:0]    ram_waddr, ram_raddr;
    logic [EW-1:0]    ram_wdata, ram_rdata;
    logic [TimeW-1:0] rd_dl;
    logic [SB-1:0]    rd_handle;
    logic [PW-1:0]    a_pos, a_prev, head_inc;
    logic             full;

    // logical queue slot to ring address
    function automatic logic [PW-1:0] phys(input logic [PW-1:0] head,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(off);
        if (s >= SW'(QUEUE_DEPTH)) begin
            s = s - SW'(QUEUE_DEPTH);
        end
        return s[PW-1:0];
    endfunction

    assign a_pos    = phys(r_head, r_pos);
    assign a_prev   = phys(r_head, r_pos - CW'(1));
    assign head_inc = (r_head == PW'(QUEUE_DEPTH - 1)) ? '0 : r_head + PW'(1);
    assign full     = (r_count == CW'(QUEUE_DEPTH));
    assign rd_dl     = ram_rdata[SB +: TimeW];
    assign rd_handle = ram_rdata[SB-1:0];

    dotq_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_sum (alu_sum),
        .o_le  (alu_le)
    );

    dotq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_npt       = r_npt;
        n_count     = r_count;
        n_head      = r_head;
        n_pos       = r_pos;
        n_dl        = r_dl;
        n_handle    = r_handle;
        n_delay     = r_delay;
        n_out_valid = 1'b0;
        n_out       = r_out;
        alu_a       = r_now;
        alu_b       = TimeW'(r_tick);
        ram_we      = 1'b0;
        ram_waddr   = a_pos;
        ram_wdata   = {r_dl, r_handle};
        ram_raddr   = r_head;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (i_in.kind) inside
                        KIND_TICK: begin
                            n_state = ST_TICK_ADD;
                        end
                        KIND_ABS, KIND_DELAY: begin
                            if (full) begin
                                n_out_valid       = 1'b1;
                                n_out.result_kind = RES_FULL;
                                n_out.fired_handle = HandleW'(i_in.entry_handle[SB-1:0]);
                                n_out.now_ns      = r_now;
                                n_out.preempt_due = 1'b0;
                                n_out.last        = 1'b1;
                            end else begin
                                n_dl     = i_in.when_ns;
                                n_delay  = (i_in.kind == KIND_DELAY);
                                n_handle = i_in.entry_handle[SB-1:0];
                                n_pos    = r_count;
                                n_state  = ST_ADD_DL;
                            end
                        end
                        default: begin
                            n_out_valid        = 1'b1;
                            n_out.result_kind  = RES_TIME;
                            n_out.fired_handle = '0;
                            n_out.now_ns       = r_now;
                            n_out.preempt_due  = 1'b0;
                            n_out.last         = 1'b1;
                        end
                    endcase
                end
            end
            ST_TICK_ADD: begin
                n_now   = alu_sum;
                n_state = ST_POP_RD;
            end
            ST_POP_RD: begin
                n_state = (r_count == '0) ? ST_PRE_CMP : ST_POP_CMP;
            end
            ST_POP_CMP: begin
                alu_a = rd_dl;
                alu_b = r_now;
                if (alu_le) begin
                    n_out_valid        = 1'b1;
                    n_out.result_kind  = RES_EXPIRED;
                    n_out.fired_handle = HandleW'(rd_handle);
                    n_out.now_ns       = r_now;
                    n_out.preempt_due  = 1'b0;
                    n_out.last         = 1'b0;
                    n_head             = head_inc;
                    n_count            = r_count - CW'(1);
                    n_state            = ST_POP_RD;
                end else begin
                    n_state = ST_PRE_CMP;
                end
            end
            ST_PRE_CMP: begin
                alu_a = r_npt;
                alu_b = r_now;
                if (alu_le) begin
                    n_state = ST_PRE_ADD;
                end else begin
                    n_out_valid        = 1'b1;
                    n_out.result_kind  = RES_TICK;
                    n_out.fired_handle = '0;
                    n_out.now_ns       = r_now;
                    n_out.preempt_due  = 1'b0;
                    n_out.last         = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            ST_PRE_ADD: begin
                alu_a              = r_npt;
                alu_b              = TimeW'(r_sched);
                n_npt              = alu_sum;
                n_out_valid        = 1'b1;
                n_out.result_kind  = RES_TICK;
                n_out.fired_handle = '0;
                n_out.now_ns       = r_now;
                n_out.preempt_due  = 1'b1;
                n_out.last         = 1'b1;
                n_state            = ST_IDLE;
            end
            ST_ADD_DL: begin
                alu_a   = r_delay ? r_now : '0;
                alu_b   = r_dl;
                n_dl    = alu_sum;
                n_state = ST_INS_RD;
            end
            ST_INS_RD: begin
                ram_raddr = a_prev;
                if (r_pos == '0) begin
                    ram_we             = 1'b1;
                    n_count            = r_count + CW'(1);
                    n_out_valid        = 1'b1;
                    n_out.result_kind  = RES_ADDED;
                    n_out.fired_handle = HandleW'(r_handle);
                    n_out.now_ns       = r_now;
                    n_out.preempt_due  = 1'b0;
                    n_out.last         = 1'b1;
                    n_state            = ST_IDLE;
                end else begin
                    n_state = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                alu_a  = rd_dl;
                alu_b  = r_dl;
                ram_we = 1'b1;
                if (alu_le) begin
                    // slot found: new entry goes after the equal-or-earlier one
                    n_count            = r_count + CW'(1);
                    n_out_valid        = 1'b1;
                    n_out.result_kind  = RES_ADDED;
                    n_out.fired_handle = HandleW'(r_handle);
                    n_out.now_ns       = r_now;
                    n_out.preempt_due  = 1'b0;
                    n_out.last         = 1'b1;
                    n_state            = ST_IDLE;
                end else begin
                    ram_wdata = ram_rdata;
                    n_pos     = r_pos - CW'(1);
                    n_state   = ST_INS_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_now       <= '0;
            r_npt       <= '0;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_npt       <= n_npt;
            r_count     <= n_count;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_dl     <= n_dl;
        r_handle <= n_handle;
        r_delay  <= n_delay;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= TICK_PERIOD_RST;
            r_sched <= SCHED_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TICK:  r_tick  <= i_cfg_data;
                CFG_SCHED: r_sched <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_out_valid;
    assign o_out    = r_out;

    `DOTQ_ASSERT_IMP(a_mid_word_busy, o_strobe && !o_out.last, busy, "non-final word while idle")
    `DOTQ_ASSERT_NXT(a_tick_busy, start && !busy && (i_in.kind == KIND_TICK), busy, "tick not taken")
    `DOTQ_ASSERT_IMP(a_pop_nonempty, r_state == ST_POP_CMP, r_count != '0, "pop from empty queue")
    `DOTQ_ASSERT_IMP(a_ins_not_full, r_state == ST_INS_RD || r_state == ST_INS_CMP, !full, "insert into full queue")

endmodule
`default_nettype wire

FILE: test/deadline_ordered_timer_queue_unit_tb.sv
`timescale 1ns / 1ps
module deadline_ordered_timer_queue_unit_tb;
    import dotq_pkg::*;

    localparam int QueueDepth = 32;
    localparam int StallLimit = 2000;
    localparam logic [CfgIdxW-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_SPARE_3 = 2'd3;
    localparam logic [TimeW-1:0]   TIME_MAX    = '1;

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               start    = 1'b0;
    logic               busy;
    t_in_word           in_word  = '0;
    logic               o_strobe;
    t_out_word          o_out;
    logic               cfg_we   = 1'b0;
    logic [CfgIdxW-1:0] cfg_idx  = '0;
    logic [CfgW-1:0]    cfg_data = '0;

    // timer queue model
    logic [TimeW-1:0]   sim_now;
    logic [TimeW-1:0]   sim_preempt_at;
    logic [TimeW-1:0]   sim_tick_ns;
    logic [TimeW-1:0]   sim_sched_ns;
    logic [TimeW-1:0]   sim_deadline [QueueDepth];
    logic [HandleW-1:0] sim_handle   [QueueDepth];
    int                 sim_count;

    t_out_word          pending_results [$];
    int                 err_count    = 0;
    int                 stall_cycles = 0;
    bit                 idle_enable  = 1'b1;

    deadline_ordered_timer_queue_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (in_word),
        .o_strobe   (o_strobe),
        .o_out      (o_out),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial forever #1 i_clk = ~i_clk;

    function automatic logic [TimeW-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_word make_word(input logic [1:0] kind,
                                           input logic [HandleW-1:0] handle,
                                           input logic [TimeW-1:0] when_ns);
        t_in_word w;
        w.kind         = kind;
        w.entry_handle = handle;
        w.when_ns      = when_ns;
        return w;
    endfunction

    function automatic void push_result(input logic [2:0] rkind,
                                        input logic [HandleW-1:0] handle,
                                        input logic due, input logic fin);
        t_out_word r;
        r.result_kind  = rkind;
        r.fired_handle = handle;
        r.now_ns       = sim_now;
        r.preempt_due  = due;
        r.last         = fin;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_timer_results(input t_in_word w);
        logic [TimeW-1:0] deadline;
        int               pos;
        case (w.kind) inside
            KIND_TICK: begin
                sim_now = sim_now + sim_tick_ns;
                while (sim_count > 0 && sim_deadline[0] <= sim_now) begin
                    push_result(RES_EXPIRED, sim_handle[0], 1'b0, 1'b0);
                    for (int i = 1; i < sim_count; i++) begin
                        sim_deadline[i-1] = sim_deadline[i];
                        sim_handle[i-1]   = sim_handle[i];
                    end
                    sim_count--;
                end
                // preempt deadline moves by one period at most per tick
                if (sim_now >= sim_preempt_at) begin
                    sim_preempt_at = sim_preempt_at + sim_sched_ns;
                    push_result(RES_TICK, '0, 1'b1, 1'b1);
                end else begin
                    push_result(RES_TICK, '0, 1'b0, 1'b1);
                end
            end
            KIND_ABS, KIND_DELAY: begin
                deadline = (w.kind == KIND_ABS) ? w.when_ns : sim_now + w.when_ns;
                if (sim_count >= QueueDepth) begin
                    push_result(RES_FULL, w.entry_handle, 1'b0, 1'b1);
                end else begin
                    // goes after every entry due at or before it
                    pos = 0;
                    while (pos < sim_count && sim_deadline[pos] <= deadline) pos++;
                    for (int i = sim_count; i > pos; i--) begin
                        sim_deadline[i] = sim_deadline[i-1];
                        sim_handle[i]   = sim_handle[i-1];
                    end
                    sim_deadline[pos] = deadline;
                    sim_handle[pos]   = w.entry_handle;
                    sim_count++;
                    push_result(RES_ADDED, w.entry_handle, 1'b0, 1'b1);
                end
            end
            default: begin
                push_result(RES_TIME, '0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // start stays high after the word is taken, so back-to-back words
    // drop it only when idle_enable inserts a random gap
    task automatic send_word(input t_in_word w);
        in_word <= w;
        do begin
            start <= !(idle_enable && ($urandom_range(0, 99) < 29));
            @(posedge i_clk);
        end while (busy || !start);
        predict_timer_results(w);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_TICK:  sim_tick_ns  = TimeW'(data);
            CFG_SCHED: sim_sched_ns = TimeW'(data);
            default: ;
        endcase
    endtask

    function automatic logic [CfgW-1:0] pick_period();
        case ($urandom_range(0, 4))
            0:       return 32'd1;
            1:       return CfgW'($urandom_range(1, 1000));
            2:       return TICK_PERIOD_RST;
            3:       return $urandom;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic t_in_word random_word();
        t_in_word         w;
        logic [TimeW-1:0] near;
        int               sel;
        near = sim_tick_ns * $urandom_range(0, 3) + (rand64() % (sim_tick_ns + 1));
        sel  = $urandom_range(0, 99);
        w.kind = (sel < 35) ? KIND_TICK : (sel < 60) ? KIND_ABS :
                 (sel < 85) ? KIND_DELAY : KIND_READ;
        w.entry_handle = HandleW'($urandom);
        case ($urandom_range(0, 9))
            0: w.when_ns = rand64();
            1: w.when_ns = $urandom_range(0, 1) ? TIME_MAX : '0;
            // already past; for a delay the sum wraps behind now
            2: w.when_ns = (w.kind == KIND_ABS) ? sim_now - TimeW'($urandom_range(0, 1000))
                                                : TIME_MAX - TimeW'($urandom_range(0, 1000));
            default: w.when_ns = (w.kind == KIND_ABS) ? sim_now + near : near;
        endcase
        return w;
    endfunction

    task automatic test_directed_cases();
        send_word(make_word(KIND_READ, 16'h0000, TIME_MAX));
        send_word(make_word(KIND_TICK, 16'hFFFF, '0));
        send_word(make_word(KIND_ABS, 16'h0000, '0));
        send_word(make_word(KIND_DELAY, 16'hFFFF, TIME_MAX));
        send_word(make_word(KIND_DELAY, 16'h0001, '0));
        // equal deadlines leave in arrival order
        send_word(make_word(KIND_ABS, 16'h0002, sim_now + sim_tick_ns));
        send_word(make_word(KIND_ABS, 16'h0003, sim_now + sim_tick_ns));
        send_word(make_word(KIND_DELAY, 16'h0004, sim_tick_ns));
        send_word(make_word(KIND_DELAY, 16'h0005, sim_tick_ns + 1));
        send_word(make_word(KIND_ABS, 16'h0006, sim_now + sim_tick_ns - 1));
        send_word(make_word(KIND_TICK, 16'h0000, rand64()));
        send_word(make_word(KIND_TICK, 16'h0000, rand64()));
        repeat (9) send_word(make_word(KIND_TICK, 16'h0000, rand64()));
        send_word(make_word(KIND_READ, 16'hA5A5, 64'h5A5A_5A5A_5A5A_5A5A));
    endtask

    task automatic test_full_queue();
        logic [TimeW-1:0] base;
        int               fill;
        base = sim_now;
        fill = QueueDepth - sim_count;
        for (int i = 0; i < fill; i++)
            send_word(make_word(KIND_ABS, HandleW'($urandom),
                                base + TimeW'($urandom_range(1, 4)) * (sim_tick_ns / 4)));
        send_word(make_word(KIND_ABS, HandleW'($urandom), '0));
        send_word(make_word(KIND_DELAY, HandleW'($urandom), rand64()));
        send_word(make_word(KIND_TICK, 16'h0000, rand64()));
        drain_results();
    endtask

    task automatic test_period_settings();
        write_reg(CFG_SCHED, 32'd1);
        write_reg(CFG_TICK, 32'hFFFF_FFFF);
        repeat (2) send_word(make_word(KIND_TICK, 16'h0000, rand64()));
        send_word(make_word(KIND_READ, 16'h0000, '0));
        write_reg(CFG_TICK, '0);
        write_reg(CFG_SCHED, '0);
        send_word(make_word(KIND_DELAY, 16'h1234, '0));
        repeat (2) send_word(make_word(KIND_TICK, 16'h0000, rand64()));
        write_reg(CFG_TICK, 32'd1);
        send_word(make_word(KIND_TICK, 16'h0000, rand64()));
        write_reg(CFG_SCHED, 32'hFFFF_FFFF);
        repeat (2) send_word(make_word(KIND_TICK, 16'h0000, rand64()));
        // unused indexes must leave both periods alone
        write_reg(CFG_SPARE_2, $urandom);
        write_reg(CFG_SPARE_3, $urandom);
        send_word(make_word(KIND_TICK, 16'h0000, rand64()));
        send_word(make_word(KIND_ABS, 16'hFFFF, TIME_MAX));
        drain_results();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++) begin
            write_reg(CFG_TICK, pick_period());
            write_reg(CFG_SCHED, pick_period());
            idle_enable = (phase != 2);
            for (int n = 0; n < 40; n++) begin
                send_word(random_word());
                if ($urandom_range(0, 99) == 0) drain_results();
            end
        end
        idle_enable = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [TimeW-1:0] want,
                               input logic [TimeW-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("result word with none pending: kind %0d handle %0h",
                       o_out.result_kind, o_out.fired_handle);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", TimeW'(want.result_kind), TimeW'(o_out.result_kind));
                check_field("fired_handle", TimeW'(want.fired_handle),
                            TimeW'(o_out.fired_handle));
                check_field("now_ns", want.now_ns, o_out.now_ns);
                check_field("preempt_due", TimeW'(want.preempt_due), TimeW'(o_out.preempt_due));
                check_field("last", TimeW'(want.last), TimeW'(o_out.last));
            end
        end
    end

    // any taken word in either direction counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= StallLimit) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        sim_now        = '0;
        sim_preempt_at = '0;
        sim_tick_ns    = TimeW'(TICK_PERIOD_RST);
        sim_sched_ns   = TimeW'(SCHED_PERIOD_RST);
        sim_count      = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_full_queue();
        test_period_settings();
        test_random_traffic();
        drain_results();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
